### hdl/p1_telegram_crc_receiver_defines.svh
// Assertion macros for the P1 telegram CRC receiver.
// Used by the top level; expects clk and arst_n in scope.
`ifndef P1_TELEGRAM_CRC_RECEIVER_DEFINES_SVH
`define P1_TELEGRAM_CRC_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define P1CRC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("p1crc check failed");

// Next-cycle implication, disabled during reset
`define P1CRC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("p1crc check failed");

`endif

### hdl/p1crc_pkg.sv
// Shared types, constants and byte functions of the P1 telegram CRC receiver.
// No dependencies.
`default_nettype none

package p1crc_pkg;

	localparam int CNT_W = 12;

	localparam logic [15:0] CRC_POLY    = 16'hA001;
	localparam logic [7:0]  SOF_CHAR    = 8'h2F;   // '/'
	localparam logic [7:0]  EOT_CHAR    = 8'h21;   // '!'
	localparam logic [2:0]  CAPTURE_LEN = 3'd4;    // hex digits after '!'

	// One result transaction
	typedef struct packed {
		logic             crc_ok;
		logic [15:0]      computed_crc;
		logic [15:0]      received_crc;
		logic [CNT_W-1:0] frame_length;
		logic             short_frame;
		logic             overflow;
		logic             bad_hex;
	} result_t;

	// Handshake between the frame logic and the stages around it
	typedef struct packed {
		logic go;     // the staged byte is consumed this cycle
		logic emit;   // the staged byte completes a telegram
	} step_ctl_t;

	// CRC-16/ARC update over one byte (reflected, LSB first)
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0])
				c = (c >> 1) ^ CRC_POLY;
			else
				c = c >> 1;
		end
		return c;
	endfunction

	// Upper-case hex digit decode: bit 4 set means not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		if (b >= 8'h30 && b <= 8'h39)
			v = {1'b0, 4'(b - 8'h30)};
		else if (b >= 8'h41 && b <= 8'h46)
			v = {1'b0, 4'(b - 8'h41 + 8'd10)};
		else
			v = 5'h10;
		return v;
	endfunction

endpackage

`default_nettype wire

### hdl/p1_telegram_crc_receiver.sv
// P1 telegram CRC receiver. Takes one byte per cycle, sustained, as long as
// results are taken; each byte is held in an input register and the telegram
// update loads the result register from that register, so a result is
// presented once the last CRC character has moved on. The per-cycle
// work is one byte-wide CRC-16/ARC update plus the framing and hex-capture logic.
// A '/' always opens a new telegram; bytes outside a telegram are ignored. One
// result transaction follows the fourth character after '!', carrying both CRCs,
// the length (saturating at MAX_LEN, capped at 4095) and the short, overflow and
// bad-hex flags. A completing byte holds in the input register while the
// result register is still stalled.
`default_nettype none
`include "p1_telegram_crc_receiver_defines.svh"

module p1_telegram_crc_receiver #(
	parameter int MAX_LEN = 2048,
	parameter int MIN_LEN = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             crc_ok,
	output logic [15:0]      computed_crc,
	output logic [15:0]      received_crc,
	output logic [11:0]      frame_length,
	output logic             short_frame,
	output logic             overflow,
	output logic             bad_hex
);
	import p1crc_pkg::*;

	localparam int LenLimitInt = (MAX_LEN > 4095) ? 4095 : MAX_LEN;
	localparam logic [CNT_W-1:0] LEN_LIMIT = CNT_W'(LenLimitInt);

	step_ctl_t  ctl;
	result_t    result;
	result_t    res_q;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       out_free;
	logic       ok_clean;
	logic       zeroed;

	p1crc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.ctl      (ctl),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	p1crc_frame #(
		.MAX_LEN (MAX_LEN),
		.MIN_LEN (MIN_LEN)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.out_free (out_free),
		.ctl      (ctl),
		.result   (result)
	);

	p1crc_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.result    (result),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	// Drive the result ports
	assign crc_ok       = res_q.crc_ok;
	assign computed_crc = res_q.computed_crc;
	assign received_crc = res_q.received_crc;
	assign frame_length = res_q.frame_length;
	assign short_frame  = res_q.short_frame;
	assign overflow     = res_q.overflow;
	assign bad_hex      = res_q.bad_hex;

	// Result consistency terms for the checks
	assign ok_clean = !short_frame && !overflow && !bad_hex && (computed_crc == received_crc);
	assign zeroed   = (!short_frame || computed_crc == 16'h0000) &&
	                  (!bad_hex || received_crc == 16'h0000);

	// Checks
	`P1CRC_ASSERT_NOW(a_ok_clean, out_valid && crc_ok, ok_clean)
	`P1CRC_ASSERT_NOW(a_zeroed, out_valid, zeroed)
	`P1CRC_ASSERT_NOW(a_len_cap, out_valid, frame_length <= LEN_LIMIT)
	`P1CRC_ASSERT_NOW(a_stall_held, in_stall, valid_s1 && ctl.emit)

endmodule

`default_nettype wire

### hdl/p1crc_in_stage.sv
// Input register of the P1 telegram CRC receiver: holds one received byte.
// Depends on p1crc_pkg.
`default_nettype none

module p1crc_in_stage (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           rx_byte,
	input  wire p1crc_pkg::step_ctl_t ctl,
	output logic                      valid_s1,
	output logic [7:0]                byte_s1
);
	import p1crc_pkg::*;

	logic take;

	// Stall only while a held byte cannot move on
	assign in_stall = valid_s1 && !ctl.go;
	assign take     = in_valid && !in_stall;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (ctl.go) begin
			valid_s1 <= 1'b0;
		end
	end

	// Capture the byte
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

`default_nettype wire

### hdl/p1crc_frame.sv
// Telegram state and per-byte update: framing, length count, CRC, hex capture.
// Depends on p1crc_pkg.
`default_nettype none

module p1crc_frame #(
	parameter int MAX_LEN = 2048,
	parameter int MIN_LEN = 10
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 valid_s1,
	input  wire logic [7:0]           byte_s1,
	input  wire logic                 out_free,
	output p1crc_pkg::step_ctl_t      ctl,
	output p1crc_pkg::result_t        result
);
	import p1crc_pkg::*;

	localparam int LenLimitInt = (MAX_LEN > 4095) ? 4095 : MAX_LEN;
	localparam logic [CNT_W-1:0] LEN_LIMIT = CNT_W'(LenLimitInt);
	localparam logic [CNT_W-1:0] MIN_CNT   = CNT_W'(MIN_LEN);

	logic             in_frame_q,   in_frame_d;
	logic [CNT_W-1:0] count_q,      count_d;
	logic [15:0]      crc_q,        crc_d;
	logic             frozen_q,     frozen_d;
	logic [2:0]       cap_q,        cap_d;
	logic [15:0]      recv_q,       recv_d;
	logic             hexerr_q,     hexerr_d;
	logic             ovf_q,        ovf_d;
	logic             emit;
	logic [4:0]       digit;
	logic             is_short;

	assign digit = hex_value(byte_s1);

	// Next state for the staged byte
	always_comb begin
		in_frame_d = in_frame_q;
		count_d    = count_q;
		crc_d      = crc_q;
		frozen_d   = frozen_q;
		cap_d      = cap_q;
		recv_d     = recv_q;
		hexerr_d   = hexerr_q;
		ovf_d      = ovf_q;
		emit       = 1'b0;
		if (byte_s1 == SOF_CHAR) begin
			// open a new telegram, drop any in progress
			in_frame_d = 1'b1;
			count_d    = CNT_W'(1);
			crc_d      = crc_byte(16'h0000, byte_s1);
			frozen_d   = 1'b0;
			cap_d      = 3'd0;
			recv_d     = 16'h0000;
			hexerr_d   = 1'b0;
			ovf_d      = 1'b0;
		end else if (in_frame_q) begin
			if (count_q < LEN_LIMIT)
				count_d = count_q + CNT_W'(1);
			else
				ovf_d = 1'b1;
			if (!frozen_q) begin
				crc_d = crc_byte(crc_q, byte_s1);
				if (byte_s1 == EOT_CHAR) begin
					frozen_d = 1'b1;
					cap_d    = CAPTURE_LEN;
				end
			end else if (cap_q == 3'd0) begin
				in_frame_d = 1'b0;
			end else begin
				if (!digit[4])
					recv_d = {recv_q[11:0], digit[3:0]};
				else
					hexerr_d = 1'b1;
				cap_d = cap_q - 3'd1;
				if (cap_q == 3'd1) begin
					in_frame_d = 1'b0;
					emit       = 1'b1;
				end
			end
		end
	end

	// Result fields from the updated state
	always_comb begin
		is_short            = (count_d <= MIN_CNT);
		result.computed_crc = is_short ? 16'h0000 : crc_d;
		result.received_crc = hexerr_d ? 16'h0000 : recv_d;
		result.frame_length = count_d;
		result.short_frame  = is_short;
		result.overflow     = ovf_d;
		result.bad_hex      = hexerr_d;
		result.crc_ok       = !is_short && !ovf_d && !hexerr_d &&
		                      (result.computed_crc == result.received_crc);
	end

	// A completing byte waits for a free result slot
	assign ctl.emit = valid_s1 && emit;
	assign ctl.go   = valid_s1 && (!emit || out_free);

	// Advance the telegram state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			count_q    <= '0;
			crc_q      <= '0;
			frozen_q   <= 1'b0;
			cap_q      <= '0;
			recv_q     <= '0;
			hexerr_q   <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (ctl.go) begin
			in_frame_q <= in_frame_d;
			count_q    <= count_d;
			crc_q      <= crc_d;
			frozen_q   <= frozen_d;
			cap_q      <= cap_d;
			recv_q     <= recv_d;
			hexerr_q   <= hexerr_d;
			ovf_q      <= ovf_d;
		end
	end

endmodule

`default_nettype wire

### hdl/p1crc_out_reg.sv
// Result register of the P1 telegram CRC receiver.
// Depends on p1crc_pkg.
`default_nettype none

module p1crc_out_reg (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire p1crc_pkg::step_ctl_t ctl,
	input  wire p1crc_pkg::result_t   result,
	input  wire logic                 out_stall,
	output logic                      out_free,
	output logic                      out_valid,
	output p1crc_pkg::result_t        res_q
);
	import p1crc_pkg::*;

	logic load;

	assign out_free = !out_valid || !out_stall;
	assign load     = ctl.go && ctl.emit;

	// Hold a stalled transaction, otherwise take the new one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

endmodule

`default_nettype wire
